[rtl/rkit_pkg.sv]
// Shared types and constants for the reference-counted key intern table.
package rkit_pkg;

   localparam int CAPACITY = 1024;
   localparam int SLOT_W   = 10;
   localparam int CNT_W    = 11;
   localparam int KEY_W    = 256;
   localparam int REF_W    = 32;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [REF_W-1:0] REF_MAX = '1;

   typedef enum logic [3:0] {
      OP_ACQUIRE  = 4'd0,
      OP_RELEASE  = 4'd1,
      OP_RETAIN   = 4'd2,
      OP_QUERY    = 4'd3,
      OP_REMOVE   = 4'd4,
      OP_REFRESH  = 4'd5,
      OP_FALLBACK = 4'd6,
      OP_RESET    = 4'd7,
      OP_ITERATE  = 4'd8,
      OP_NONE     = 4'd15
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_FULL  = 3'd1,
      ST_RANGE = 3'd2,
      ST_ZERO  = 3'd3,
      ST_END   = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ACQ_RD,
      S_ACQ_CHK,
      S_IDX_RD,
      S_IDX_CHK,
      S_REF_RD,
      S_REF_CHK,
      S_ITER_RD,
      S_ITER_CHK
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] idx;
      logic              range_err;
      logic [CNT_W-1:0]  root;
      logic [CNT_W-1:0]  cursor;
   } item_type;

endpackage

[rtl/rkit_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rkit_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rkit_front.sv]
// Front end: accepts request transactions, classifies them and queues them.
module rkit_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_operation,
   input  logic [63:0]                  req_key_w0,
   input  logic [63:0]                  req_key_w1,
   input  logic [63:0]                  req_key_w2,
   input  logic [63:0]                  req_key_w3,
   input  logic [rkit_pkg::SLOT_W-1:0]  req_entry_index,
   input  logic [rkit_pkg::CNT_W-1:0]   req_root_count,
   input  logic [rkit_pkg::CNT_W-1:0]   req_cursor,
   output logic                         q_valid,
   output rkit_pkg::item_type           q_item,
   input  logic                         q_pop
);

   rkit_pkg::item_type item_new;
   rkit_pkg::op_type   op_dec;
   rkit_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;

   // classify the operation code
   always_comb begin
      case (req_operation)
         rkit_pkg::OP_ACQUIRE:  op_dec = rkit_pkg::OP_ACQUIRE;
         rkit_pkg::OP_RELEASE:  op_dec = rkit_pkg::OP_RELEASE;
         rkit_pkg::OP_RETAIN:   op_dec = rkit_pkg::OP_RETAIN;
         rkit_pkg::OP_QUERY:    op_dec = rkit_pkg::OP_QUERY;
         rkit_pkg::OP_REMOVE:   op_dec = rkit_pkg::OP_REMOVE;
         rkit_pkg::OP_REFRESH:  op_dec = rkit_pkg::OP_REFRESH;
         rkit_pkg::OP_FALLBACK: op_dec = rkit_pkg::OP_FALLBACK;
         rkit_pkg::OP_RESET:    op_dec = rkit_pkg::OP_RESET;
         rkit_pkg::OP_ITERATE:  op_dec = rkit_pkg::OP_ITERATE;
         default:               op_dec = rkit_pkg::OP_NONE;
      endcase
   end

   // pack the transaction and flag an index beyond the table
   always_comb begin
      item_new.op        = op_dec;
      item_new.key       = {req_key_w3, req_key_w2, req_key_w1, req_key_w0};
      item_new.idx       = req_entry_index;
      item_new.range_err = ({1'b0, req_entry_index} >= rkit_pkg::CAP_CNT);
      item_new.root      = req_root_count;
      item_new.cursor    = req_cursor;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // advance the queue pointers
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued payloads
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

[rtl/rkit_back.sv]
// Back end: executes queued transactions on the key and count memories.
module rkit_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  rkit_pkg::item_type           q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [rkit_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [63:0]                  rsp_out_w0,
   output logic [63:0]                  rsp_out_w1,
   output logic [63:0]                  rsp_out_w2,
   output logic [63:0]                  rsp_out_w3,
   output logic [rkit_pkg::CNT_W-1:0]   rsp_next_cursor,
   output logic [rkit_pkg::CNT_W-1:0]   rsp_used_entries,
   output logic                         rsp_fallback_mode
);

   localparam int SW = rkit_pkg::SLOT_W;
   localparam int CW = rkit_pkg::CNT_W;
   localparam int KW = rkit_pkg::KEY_W;
   localparam int RW = rkit_pkg::REF_W;

   rkit_pkg::state_type state_ff, state_in;
   rkit_pkg::item_type  it_ff, it_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       free_ff, free_in;
   logic [CW-1:0]       hw_ff, hw_in;
   logic [CW-1:0]       used_ff, used_in;
   logic                fb_ff, fb_in;
   logic [CW-1:0]       clr_end_ff, clr_end_in;
   logic                clr_op_ff, clr_op_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [SW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [KW-1:0]       rsp_key_ff, rsp_key_in;
   logic [CW-1:0]       rsp_ncur_ff, rsp_ncur_in;
   logic [CW-1:0]       rsp_used_ff, rsp_used_in;
   logic                rsp_fb_ff, rsp_fb_in;
   logic                emit;

   logic                cnt_we;
   logic [SW-1:0]       cnt_wa;
   logic [RW-1:0]       cnt_wd;
   logic [RW-1:0]       cnt_q;
   logic                key_we;
   logic [SW-1:0]       key_wa;
   logic [KW-1:0]       key_q;

   logic                go;
   logic                cnt_nz;
   logic                key_hit;
   logic [CW-1:0]       pos_inc;
   logic                pos_last;
   logic                clr_last;
   logic [RW-1:0]       cnt_up;
   rkit_pkg::item_type  cur_item;
   logic [CW-1:0]       dec_free;
   logic [CW-1:0]       slot_new;
   logic                tbl_full;
   logic [CW-1:0]       slot_inc;

   // count memory: one word per slot
   rkit_ram #(.WIDTH(RW), .DEPTH(rkit_pkg::CAPACITY)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (pos_ff[SW-1:0]),
      .rd_data (cnt_q)
   );

   // key memory: one 256-bit row per slot
   rkit_ram #(.WIDTH(KW), .DEPTH(rkit_pkg::CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (cur_item.key),
      .rd_addr (pos_ff[SW-1:0]),
      .rd_data (key_q)
   );

   // shared conditions
   assign go       = q_valid && !rsp_valid_ff;
   assign cnt_nz   = (cnt_q != '0);
   assign key_hit  = cnt_nz && (key_q == it_ff.key);
   assign pos_inc  = pos_ff + 1'b1;
   assign pos_last = (pos_inc >= hw_ff);
   assign clr_last = (pos_inc >= clr_end_ff);
   assign cnt_up   = (cnt_q == rkit_pkg::REF_MAX) ? cnt_q : cnt_q + 1'b1;
   assign cur_item = (state_ff == rkit_pkg::S_IDLE) ? q_item : it_ff;
   assign q_pop    = (state_ff == rkit_pkg::S_IDLE) && go;

   // pick the slot for a new key: lowest free one seen, else the high water mark
   always_comb begin
      if (state_ff == rkit_pkg::S_IDLE) begin
         dec_free = rkit_pkg::CAP_CNT;
      end else if (free_ff == rkit_pkg::CAP_CNT && !cnt_nz) begin
         dec_free = pos_ff;
      end else begin
         dec_free = free_ff;
      end
      slot_new = (dec_free != rkit_pkg::CAP_CNT) ? dec_free : hw_ff;
      tbl_full = (slot_new == rkit_pkg::CAP_CNT);
      slot_inc = slot_new + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rkit_pkg::S_CLEAR: begin
            if (clr_last) state_in = rkit_pkg::S_IDLE;
         end
         rkit_pkg::S_IDLE: begin
            if (go) begin
               case (q_item.op)
                  rkit_pkg::OP_ACQUIRE, rkit_pkg::OP_FALLBACK: begin
                     if (hw_ff != '0) state_in = rkit_pkg::S_ACQ_RD;
                  end
                  rkit_pkg::OP_RELEASE, rkit_pkg::OP_RETAIN,
                  rkit_pkg::OP_QUERY, rkit_pkg::OP_REMOVE: begin
                     if (!q_item.range_err) state_in = rkit_pkg::S_IDX_RD;
                  end
                  rkit_pkg::OP_REFRESH: begin
                     if (hw_ff != '0) state_in = rkit_pkg::S_REF_RD;
                  end
                  rkit_pkg::OP_RESET: begin
                     if (hw_ff != '0) state_in = rkit_pkg::S_CLEAR;
                  end
                  rkit_pkg::OP_ITERATE: begin
                     if (q_item.cursor < hw_ff) state_in = rkit_pkg::S_ITER_RD;
                  end
                  default: state_in = rkit_pkg::S_IDLE;
               endcase
            end
         end
         rkit_pkg::S_ACQ_RD:  state_in = rkit_pkg::S_ACQ_CHK;
         rkit_pkg::S_ACQ_CHK: begin
            state_in = (key_hit || pos_last) ? rkit_pkg::S_IDLE : rkit_pkg::S_ACQ_RD;
         end
         rkit_pkg::S_IDX_RD:  state_in = rkit_pkg::S_IDX_CHK;
         rkit_pkg::S_IDX_CHK: state_in = rkit_pkg::S_IDLE;
         rkit_pkg::S_REF_RD:  state_in = rkit_pkg::S_REF_CHK;
         rkit_pkg::S_REF_CHK: begin
            state_in = pos_last ? rkit_pkg::S_IDLE : rkit_pkg::S_REF_RD;
         end
         rkit_pkg::S_ITER_RD: state_in = rkit_pkg::S_ITER_CHK;
         rkit_pkg::S_ITER_CHK: begin
            state_in = (cnt_nz || pos_last) ? rkit_pkg::S_IDLE : rkit_pkg::S_ITER_RD;
         end
         default: state_in = rkit_pkg::S_IDLE;
      endcase
   end

   // datapath, memory writes and result
   always_comb begin
      it_in         = it_ff;
      pos_in        = pos_ff;
      free_in       = free_ff;
      hw_in         = hw_ff;
      used_in       = used_ff;
      fb_in         = fb_ff;
      clr_end_in    = clr_end_ff;
      clr_op_in     = clr_op_ff;
      cnt_we        = 1'b0;
      cnt_wa        = pos_ff[SW-1:0];
      cnt_wd        = '0;
      key_we        = 1'b0;
      key_wa        = slot_new[SW-1:0];
      emit          = 1'b0;
      rsp_status_in = rkit_pkg::ST_OK;
      rsp_slot_in   = '0;
      rsp_key_in    = '0;
      rsp_ncur_in   = '0;

      case (state_ff)
         rkit_pkg::S_CLEAR: begin
            cnt_we = 1'b1;
            pos_in = pos_inc;
            if (clr_last) begin
               pos_in = '0;
               if (clr_op_ff) begin
                  hw_in     = '0;
                  used_in   = '0;
                  fb_in     = 1'b0;
                  clr_op_in = 1'b0;
                  emit      = 1'b1;
               end
            end
         end
         rkit_pkg::S_IDLE: begin
            if (go) begin
               it_in   = q_item;
               free_in = rkit_pkg::CAP_CNT;
               pos_in  = '0;
               case (q_item.op)
                  rkit_pkg::OP_ACQUIRE, rkit_pkg::OP_FALLBACK: begin
                     // empty table: place the key at slot zero at once
                     if (hw_ff == '0) begin
                        key_we      = 1'b1;
                        cnt_we      = 1'b1;
                        cnt_wa      = '0;
                        cnt_wd      = RW'(1);
                        hw_in       = CW'(1);
                        used_in     = used_ff + 1'b1;
                        if (q_item.op == rkit_pkg::OP_FALLBACK) fb_in = 1'b1;
                        emit        = 1'b1;
                     end
                  end
                  rkit_pkg::OP_RELEASE, rkit_pkg::OP_RETAIN,
                  rkit_pkg::OP_QUERY, rkit_pkg::OP_REMOVE: begin
                     if (q_item.range_err) begin
                        rsp_status_in = rkit_pkg::ST_RANGE;
                        emit          = 1'b1;
                     end else begin
                        pos_in = {1'b0, q_item.idx};
                     end
                  end
                  rkit_pkg::OP_REFRESH: begin
                     if (hw_ff == '0) begin
                        if (fb_ff && used_ff == q_item.root) fb_in = 1'b0;
                        emit = 1'b1;
                     end
                  end
                  rkit_pkg::OP_RESET: begin
                     if (hw_ff == '0) begin
                        used_in = '0;
                        fb_in   = 1'b0;
                        emit    = 1'b1;
                     end else begin
                        clr_end_in = hw_ff;
                        clr_op_in  = 1'b1;
                     end
                  end
                  rkit_pkg::OP_ITERATE: begin
                     if (q_item.cursor >= hw_ff) begin
                        rsp_status_in = rkit_pkg::ST_END;
                        rsp_ncur_in   = q_item.cursor;
                        emit          = 1'b1;
                     end else begin
                        pos_in = q_item.cursor;
                     end
                  end
                  default: emit = 1'b1;
               endcase
            end
         end
         rkit_pkg::S_ACQ_CHK: begin
            if (key_hit) begin
               // key already live: count up
               cnt_we      = 1'b1;
               cnt_wd      = cnt_up;
               rsp_slot_in = pos_ff[SW-1:0];
               if (it_ff.op == rkit_pkg::OP_FALLBACK) fb_in = 1'b1;
               emit        = 1'b1;
            end else if (pos_last) begin
               if (tbl_full) begin
                  rsp_status_in = rkit_pkg::ST_FULL;
               end else begin
                  key_we      = 1'b1;
                  cnt_we      = 1'b1;
                  cnt_wa      = slot_new[SW-1:0];
                  cnt_wd      = RW'(1);
                  if (slot_inc > hw_ff) hw_in = slot_inc;
                  used_in     = used_ff + 1'b1;
                  rsp_slot_in = slot_new[SW-1:0];
                  if (it_ff.op == rkit_pkg::OP_FALLBACK) fb_in = 1'b1;
               end
               emit = 1'b1;
            end else begin
               free_in = dec_free;
               pos_in  = pos_inc;
            end
         end
         rkit_pkg::S_IDX_CHK: begin
            emit = 1'b1;
            if (it_ff.op == rkit_pkg::OP_QUERY) begin
               rsp_key_in = key_q;
            end else if (!cnt_nz) begin
               rsp_status_in = rkit_pkg::ST_ZERO;
            end else begin
               case (it_ff.op)
                  rkit_pkg::OP_RELEASE: begin
                     if (!fb_ff) begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_q - 1'b1;
                        if (cnt_q == RW'(1)) used_in = used_ff - 1'b1;
                     end
                  end
                  rkit_pkg::OP_RETAIN: begin
                     cnt_we = 1'b1;
                     cnt_wd = cnt_up;
                  end
                  rkit_pkg::OP_REMOVE: begin
                     cnt_we  = 1'b1;
                     used_in = used_ff - 1'b1;
                  end
                  default: cnt_we = 1'b0;
               endcase
            end
         end
         rkit_pkg::S_REF_CHK: begin
            // set live counts back to one
            if (cnt_nz) begin
               cnt_we = 1'b1;
               cnt_wd = RW'(1);
            end
            if (pos_last) begin
               if (fb_ff && used_ff == it_ff.root) fb_in = 1'b0;
               emit = 1'b1;
            end else begin
               pos_in = pos_inc;
            end
         end
         rkit_pkg::S_ITER_CHK: begin
            if (cnt_nz) begin
               rsp_slot_in = pos_ff[SW-1:0];
               rsp_ncur_in = pos_inc;
               emit        = 1'b1;
            end else if (pos_last) begin
               rsp_status_in = rkit_pkg::ST_END;
               rsp_ncur_in   = hw_ff;
               emit          = 1'b1;
            end else begin
               pos_in = pos_inc;
            end
         end
         default: emit = 1'b0;
      endcase

      // load the output register or drain it
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
      rsp_used_in  = used_in;
      rsp_fb_in    = fb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rkit_pkg::S_CLEAR;
         pos_ff       <= '0;
         free_ff      <= rkit_pkg::CAP_CNT;
         hw_ff        <= '0;
         used_ff      <= '0;
         fb_ff        <= 1'b0;
         clr_end_ff   <= rkit_pkg::CAP_CNT;
         clr_op_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         free_ff      <= free_in;
         hw_ff        <= hw_in;
         used_ff      <= used_in;
         fb_ff        <= fb_in;
         clr_end_ff   <= clr_end_in;
         clr_op_ff    <= clr_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the item and the result payload
   always_ff @(posedge clock) begin
      it_ff <= it_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_ncur_ff   <= rsp_ncur_in;
         rsp_used_ff   <= rsp_used_in;
         rsp_fb_ff     <= rsp_fb_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_out_w0        = rsp_key_ff[63:0];
   assign rsp_out_w1        = rsp_key_ff[127:64];
   assign rsp_out_w2        = rsp_key_ff[191:128];
   assign rsp_out_w3        = rsp_key_ff[255:192];
   assign rsp_next_cursor   = rsp_ncur_ff;
   assign rsp_used_entries  = rsp_used_ff;
   assign rsp_fallback_mode = rsp_fb_ff;

endmodule

[rtl/refcounted_key_intern_table_core.sv]
// Top level of the reference-counted key intern table.
// Index operations read one slot and then act on it; acquire walks the slots below high water,
// refresh and iterate walk slot by slot, and the reset op clears each slot below high water.
// Throughput is set by the back end's walk over the count and key memories (one read port each).
// After reset a clearing pass over all 1024 slots zeroes the counts; requests queue meanwhile.
// Reset is synchronous and active high; it empties the queue and the output register.
module refcounted_key_intern_table_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_operation,
   input  logic [63:0]                  req_key_w0,
   input  logic [63:0]                  req_key_w1,
   input  logic [63:0]                  req_key_w2,
   input  logic [63:0]                  req_key_w3,
   input  logic [rkit_pkg::SLOT_W-1:0]  req_entry_index,
   input  logic [rkit_pkg::CNT_W-1:0]   req_root_count,
   input  logic [rkit_pkg::CNT_W-1:0]   req_cursor,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_status,
   output logic [rkit_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [63:0]                  rsp_out_w0,
   output logic [63:0]                  rsp_out_w1,
   output logic [63:0]                  rsp_out_w2,
   output logic [63:0]                  rsp_out_w3,
   output logic [rkit_pkg::CNT_W-1:0]   rsp_next_cursor,
   output logic [rkit_pkg::CNT_W-1:0]   rsp_used_entries,
   output logic                         rsp_fallback_mode
);

   logic               q_valid;
   logic               q_pop;
   rkit_pkg::item_type q_item;

   // accept and classify
   rkit_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_key_w0      (req_key_w0),
      .req_key_w1      (req_key_w1),
      .req_key_w2      (req_key_w2),
      .req_key_w3      (req_key_w3),
      .req_entry_index (req_entry_index),
      .req_root_count  (req_root_count),
      .req_cursor      (req_cursor),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   // execute
   rkit_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_out_w0        (rsp_out_w0),
      .rsp_out_w1        (rsp_out_w1),
      .rsp_out_w2        (rsp_out_w2),
      .rsp_out_w3        (rsp_out_w3),
      .rsp_next_cursor   (rsp_next_cursor),
      .rsp_used_entries  (rsp_used_entries),
      .rsp_fallback_mode (rsp_fallback_mode)
   );

endmodule

[rtl/rkit_checker.sv]
// Port-level checks for the intern table, bound to the top level.
module rkit_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [2:0]                   rsp_status,
   input logic [rkit_pkg::SLOT_W-1:0]  rsp_slot_index,
   input logic [63:0]                  rsp_out_w0,
   input logic [63:0]                  rsp_out_w1,
   input logic [63:0]                  rsp_out_w2,
   input logic [63:0]                  rsp_out_w3,
   input logic [rkit_pkg::CNT_W-1:0]   rsp_next_cursor,
   input logic [rkit_pkg::CNT_W-1:0]   rsp_used_entries
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // failed transactions report slot zero
   a_err_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != rkit_pkg::ST_OK |-> rsp_slot_index == '0)
      else $error("error status with nonzero slot");

   // a key is only returned by a successful query
   a_key_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_out_w0 | rsp_out_w1 | rsp_out_w2 | rsp_out_w3) != '0)
      |-> rsp_status == rkit_pkg::ST_OK && rsp_slot_index == '0 && rsp_next_cursor == '0)
      else $error("key returned outside a query");

   // the live count never exceeds the table
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_entries <= rkit_pkg::CAP_CNT)
      else $error("used count beyond capacity");

endmodule

bind refcounted_key_intern_table_core rkit_checker u_rkit_checker (.*);
